>>> design/ring_moving_average_macros.svh
// Assertion macros shared by the moving-average block.
`ifndef RING_MOVING_AVERAGE_MACROS_SVH
`define RING_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define RMA_ASSERT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ring_moving_average: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define RMA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ring_moving_average: next-cycle check failed");

`endif

>>> design/rma_pkg.sv
`timescale 1ns / 1ps

package rma_pkg;

  // Default sizes of the ring and of one sample.
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // The window register and the fill level are both 7 bits wide.
  localparam int FILL_W = 7;
  localparam int CFG_W  = 7;
  localparam logic [CFG_W-1:0] WIN_RESET = 7'd64;

  // Sequencer states for one word.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_START,
    ST_DIV,
    ST_DONE
  } rma_state_e;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic ram_read;
    logic ram_write;
    logic sum_sub;
    logic sum_add;
    logic div_start;
    logic out_load;
  } rma_ctrl_t;

endpackage

>>> design/rma_ram.sv
`timescale 1ns / 1ps

module rma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rma_div.sv
`timescale 1ns / 1ps
`include "ring_moving_average_macros.svh"

module rma_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIVIDEND_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0]      divisor_i,
  output rma_pkg::div_stat_t        stat_o,
  output logic [DIVIDEND_W-1:0]     quotient_o
);
  import rma_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] work_q, work_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;
  logic                  last;

  // One restoring step: bring down the next dividend bit and try the divisor.
  assign trial = {rem_q, work_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign last  = busy_q && (cnt_q == LAST_STEP);

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      work_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q + CNT_W'(1);
      work_d = {work_q[DIVIDEND_W-2:0], fits};
      rem_d  = fits ? DIVISOR_W'(trial - {1'b0, dsr_q}) : trial[DIVISOR_W-1:0];
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = last;
  assign quotient_o  = work_q;

  // A start always begins a run of steps.
  `RMA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i, busy_q)
  // The remainder stays below the divisor while working.
  `RMA_ASSERT(a_rem_below, clk_i, rst_ni, busy_q, rem_q < dsr_q)

endmodule

>>> design/ring_moving_average.sv
`timescale 1ns / 1ps
`include "ring_moving_average_macros.svh"
// Each accepted input word passes the states SUB, ADD, START, DIV and DONE; in DONE the result
// word is loaded into the output register, and only then is a new word taken. The serial
// divider produces one quotient bit of the running sum per cycle.
// Reset: window 64, ring empty, sum zero; sample memory is not cleared and its values
// are only used at entries already written. A window write clears the ring the same way.
module ring_moving_average #(
  parameter int MAX_WINDOW  = rma_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = rma_pkg::SAMPLE_BITS_DEF,
  parameter int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_TDATA_W = ((SAMPLE_BITS + rma_pkg::FILL_W + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Window size register write.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [rma_pkg::CFG_W-1:0] cfg_data_i,    // window_size
  // Sample words in.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_TDATA_W-1:0]    s_axis_tdata,   // sample
  // Result words out.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_TDATA_W-1:0]   m_axis_tdata    // mean_value, fill_level
);
  import rma_pkg::*;

  // The window register is 7 bits wide, so no more entries are ever addressed.
  localparam int WIN_CAP = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
  localparam int PTR_W   = (WIN_CAP > 1) ? $clog2(WIN_CAP) : 1;
  localparam int SUM_W   = SAMPLE_BITS + ((WIN_CAP > 1) ? $clog2(WIN_CAP) : 0);
  localparam logic [FILL_W-1:0] WIN_CAP_L = FILL_W'(WIN_CAP);

  typedef logic signed [SUM_W-1:0] sum_t;

  rma_state_e state_q, state_d;
  rma_ctrl_t  ctrl;
  div_stat_t  div_stat;

  logic [CFG_W-1:0]              win_q;
  logic [FILL_W-1:0]             win_eff;
  logic [PTR_W-1:0]              wpos_q, wpos_d;
  logic [PTR_W:0]                wpos_inc;
  logic [FILL_W-1:0]             count_q, count_d;
  logic                          full_q;
  sum_t                          sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic signed [SAMPLE_BITS-1:0] old_smp;
  logic                          neg_q;
  logic [SUM_W-1:0]              div_dividend;
  logic [SUM_W-1:0]              quotient;
  logic                          out_valid_q;
  logic [SAMPLE_BITS-1:0]        out_mean_q;
  logic [FILL_W-1:0]             out_fill_q;
  logic                          in_fire;
  logic                          cfg_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  // Window zero acts as one; anything above the ring size saturates.
  always_comb begin
    priority if (win_q == '0) begin
      win_eff = FILL_W'(1);
    end else if (win_q > WIN_CAP_L) begin
      win_eff = WIN_CAP_L;
    end else begin
      win_eff = win_q;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_SUB;
      ST_SUB:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_stat.done) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Strobes of the sequencer.
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.ram_read = s_axis_tvalid;
      end
      ST_SUB: begin
        ctrl.sum_sub   = full_q;
        ctrl.ram_write = 1'b1;
      end
      ST_ADD:   ctrl.sum_add   = 1'b1;
      ST_START: ctrl.div_start = 1'b1;
      ST_DIV:   ctrl = '0;
      ST_DONE:  ctrl.out_load  = !out_valid_q || m_axis_tready;
      default:  ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = ctrl.in_ready;
  assign cfg_ready_o   = (state_q == ST_IDLE);

  // Sample ring: the entry about to be overwritten is read as the word arrives.
  rma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WIN_CAP),
    .AW    (PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.ram_write),
    .waddr_i (wpos_q),
    .wdata_i (smp_q),
    .re_i    (ctrl.ram_read),
    .raddr_i (wpos_q),
    .rdata_o (old_smp)
  );

  // Ring position, fill count and running sum.
  assign wpos_inc = {1'b0, wpos_q} + (PTR_W + 1)'(1);

  always_comb begin
    wpos_d  = wpos_q;
    count_d = count_q;
    sum_d   = sum_q;
    if (cfg_fire) begin
      wpos_d  = '0;
      count_d = '0;
      sum_d   = '0;
    end else begin
      if (ctrl.sum_sub) begin
        sum_d = sum_q - sum_t'(old_smp);
      end
      if (ctrl.sum_add) begin
        sum_d   = sum_q + sum_t'(smp_q);
        wpos_d  = (FILL_W'(wpos_inc) >= win_eff) ? '0 : wpos_inc[PTR_W-1:0];
        count_d = full_q ? win_eff : count_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= WIN_RESET;
      wpos_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      if (cfg_fire) begin
        win_q <= cfg_data_i;
      end
      wpos_q  <= wpos_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // Per-word operands.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q  <= s_axis_tdata[SAMPLE_BITS-1:0];
      full_q <= count_q >= win_eff;
    end
    if (ctrl.div_start) begin
      neg_q <= sum_q[SUM_W-1];
    end
  end

  // Divide the magnitude, then restore the sign: truncation toward zero.
  assign div_dividend = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  rma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (FILL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Output register, so the next word can start while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_mean_q <= neg_q ? -quotient[SAMPLE_BITS-1:0] : quotient[SAMPLE_BITS-1:0];
      out_fill_q <= count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_fill_q, out_mean_q});

  // Sanity of the ring state and the sequencing.
  `RMA_ASSERT(a_ready_div_idle, clk_i, rst_ni, s_axis_tready, !div_stat.busy)
  `RMA_ASSERT(a_count_in_window, clk_i, rst_ni, 1'b1, count_q <= win_eff)
  `RMA_ASSERT(a_pos_in_window, clk_i, rst_ni, 1'b1, FILL_W'(wpos_q) < win_eff)
  `RMA_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_fire, state_q == ST_SUB)

endmodule
